// ----- rtl/flat_triangle_normal_expander_unit_assert.svh -----
`ifndef FLAT_TRIANGLE_NORMAL_EXPANDER_UNIT_ASSERT_SVH
`define FLAT_TRIANGLE_NORMAL_EXPANDER_UNIT_ASSERT_SVH

// same-cycle implication
`define FTNE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FTNE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ftne_pkg.sv -----
`timescale 1ns / 1ps
package ftne_pkg;
   localparam int NODE_DEPTH  = 4096;
   localparam int NODE_BITS   = 12;
   localparam int COUNT_BITS  = 13;
   localparam int COORD_BITS  = 24;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS    = PROD_BITS;
   localparam int CNT_BITS    = 24;
   localparam int NORM_BITS   = 16;
   localparam int Q_BITS      = 15;
   localparam int STEP_BITS   = 5;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_TRI     = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EDGE, ST_MUL, ST_MAG, ST_NORM,
      ST_SQ, ST_SQRT, ST_DIV, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_READ, OP_EDGE, OP_MUL, OP_MAG, OP_NORM,
      OP_SQ, OP_SQRT, OP_DIV, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [STEP_BITS-1:0] step;
      logic [1:0]           comp;
   } cmd_type;

   typedef struct packed {
      logic tri_go;
      logic norm_done;
      logic mag_zero;
   } sts_type;
endpackage

// ----- rtl/ftne_ctrl.sv -----
`timescale 1ns / 1ps
module ftne_ctrl
   import ftne_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [1:0]           comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      comp_in  = comp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            comp_in = '0;
            if (req_valid && sts.tri_go) state_in = ST_READ;
         end
         ST_READ: begin
            if (step_ff == STEP_BITS'(3)) begin
               state_in = ST_EDGE;
               step_in  = '0;
            end else step_in = step_ff + 1'b1;
         end
         ST_EDGE: begin
            state_in = ST_MUL;
            step_in  = '0;
         end
         ST_MUL: begin
            if (step_ff == STEP_BITS'(6)) begin
               state_in = ST_MAG;
               step_in  = '0;
            end else step_in = step_ff + 1'b1;
         end
         ST_MAG: state_in = ST_NORM;
         ST_NORM: begin
            step_in = '0;
            if (sts.mag_zero) state_in = ST_EMIT;
            else if (sts.norm_done) state_in = ST_SQ;
         end
         ST_SQ: begin
            if (step_ff == STEP_BITS'(3)) begin
               state_in = ST_SQRT;
               step_in  = '0;
            end else step_in = step_ff + 1'b1;
         end
         ST_SQRT: begin
            if (step_ff == STEP_BITS'(31)) begin
               state_in = ST_DIV;
               step_in  = '0;
               comp_in  = '0;
            end else step_in = step_ff + 1'b1;
         end
         ST_DIV: begin
            if (step_ff == STEP_BITS'(15)) begin
               step_in = '0;
               if (comp_ff == 2'd2) state_in = ST_EMIT;
               else comp_in = comp_ff + 1'b1;
            end else step_in = step_ff + 1'b1;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (step_ff == STEP_BITS'(2)) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end else step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.op    = OP_NONE;
      cmd.step  = step_ff;
      cmd.comp  = comp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_READ: cmd.op = OP_READ;
         ST_EDGE: cmd.op = OP_EDGE;
         ST_MUL:  cmd.op = OP_MUL;
         ST_MAG:  cmd.op = OP_MAG;
         ST_NORM: cmd.op = OP_NORM;
         ST_SQ:   cmd.op = OP_SQ;
         ST_SQRT: cmd.op = OP_SQRT;
         ST_DIV:  cmd.op = OP_DIV;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) cmd.op = OP_EMIT;
         end
         default: cmd.op = OP_NONE;
      endcase
   end
endmodule

// ----- rtl/ftne_dp.sv -----
`timescale 1ns / 1ps
module ftne_dp
   import ftne_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   input  logic                         csr_write_enable,
   input  logic [COUNT_BITS-1:0]        csr_write_data,
   input  logic [1:0]                   req_action,
   input  logic [NODE_BITS-1:0]         req_node_a,
   input  logic [NODE_BITS-1:0]         req_node_b,
   input  logic [NODE_BITS-1:0]         req_node_c,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   output logic signed [COORD_BITS-1:0] rsp_vert_x,
   output logic signed [COORD_BITS-1:0] rsp_vert_y,
   output logic signed [COORD_BITS-1:0] rsp_vert_z,
   output logic signed [NORM_BITS-1:0]  rsp_norm_x,
   output logic signed [NORM_BITS-1:0]  rsp_norm_y,
   output logic signed [NORM_BITS-1:0]  rsp_norm_z,
   output logic [CNT_BITS-1:0]          rsp_vertex_index,
   output logic                         rsp_last_corner
);
   logic [3*COORD_BITS-1:0]      mem [NODE_DEPTH];
   logic [3*COORD_BITS-1:0]      rd_q_ff;
   logic [NODE_BITS-1:0]         rd_addr;
   logic [COUNT_BITS-1:0]        node_count_ff;
   logic [CNT_BITS-1:0]          vcnt_ff;
   logic [NODE_BITS-1:0]         idx_ff [3];
   logic signed [COORD_BITS-1:0] px_ff [3];
   logic signed [COORD_BITS-1:0] py_ff [3];
   logic signed [COORD_BITS-1:0] pz_ff [3];
   logic signed [DIFF_BITS-1:0]  e_ff [6];
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [CROSS_BITS-1:0] c_ff [3];
   logic [MAG_BITS-1:0]          mg_ff [3];
   logic [2:0]                   neg_ff;
   logic [MAG_BITS-1:0]          mg_or;
   logic [63:0]                  sq_ff;
   logic [63:0]                  sum_ff;
   logic [34:0]                  rem_ff;
   logic [31:0]                  root_ff;
   logic [32:0]                  drem_ff;
   logic [Q_BITS-1:0]            q_ff;
   logic signed [NORM_BITS-1:0]  norm_ff [3];
   logic signed [DIFF_BITS-1:0]  mul_a, mul_b;
   logic [34:0]                  sq_rem_sh, sq_trial;
   logic [32:0]                  div_t;
   logic                         div_ge;
   logic [Q_BITS-1:0]            q_next;
   logic [1:0]                   corner;
   logic [2:0]                   pair;

   assign sts.tri_go = (req_action == ACT_TRI)
                       && ({1'b0, req_node_a} < node_count_ff)
                       && ({1'b0, req_node_b} < node_count_ff)
                       && ({1'b0, req_node_c} < node_count_ff);
   assign mg_or         = mg_ff[0] | mg_ff[1] | mg_ff[2];
   assign sts.mag_zero  = (mg_or == '0);
   assign sts.norm_done = (mg_or[MAG_BITS-1:31] == '0) && mg_or[30];

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= '0;
      else if (csr_write_enable) node_count_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) vcnt_ff <= '0;
      else if (cmd.op == OP_LOAD && req_action == ACT_RESTART) vcnt_ff <= '0;
      else if (cmd.op == OP_EMIT) vcnt_ff <= vcnt_ff + 1'b1;
   end

   assign rd_addr = idx_ff[cmd.step[1:0] == 2'd3 ? 2'd0 : cmd.step[1:0]];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && req_action == ACT_WRITE)
         mem[req_node_a] <= {req_pos_x, req_pos_y, req_pos_z};
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      unique case (cmd.step[2:0])
         3'd0:    begin mul_a = e_ff[1]; mul_b = e_ff[5]; end
         3'd1:    begin mul_a = e_ff[2]; mul_b = e_ff[4]; end
         3'd2:    begin mul_a = e_ff[2]; mul_b = e_ff[3]; end
         3'd3:    begin mul_a = e_ff[0]; mul_b = e_ff[5]; end
         3'd4:    begin mul_a = e_ff[0]; mul_b = e_ff[4]; end
         3'd5:    begin mul_a = e_ff[1]; mul_b = e_ff[3]; end
         default: begin mul_a = e_ff[0]; mul_b = e_ff[0]; end
      endcase
   end
   assign pair = cmd.step[2:0] - 3'd1;

   assign sq_rem_sh = {rem_ff[32:0], sum_ff[63:62]};
   assign sq_trial  = {1'b0, root_ff, 2'b01};

   assign div_t  = (cmd.step == STEP_BITS'(1)) ? drem_ff : {drem_ff[31:0], 1'b0};
   assign div_ge = (div_t >= {1'b0, root_ff});
   assign q_next = {q_ff[Q_BITS-2:0], div_ge};

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            idx_ff[0] <= req_node_a;
            idx_ff[1] <= req_node_b;
            idx_ff[2] <= req_node_c;
         end
         OP_READ: begin
            if (cmd.step[1:0] != 2'd0) begin
               px_ff[cmd.step[1:0] - 2'd1] <= rd_q_ff[3*COORD_BITS-1:2*COORD_BITS];
               py_ff[cmd.step[1:0] - 2'd1] <= rd_q_ff[2*COORD_BITS-1:COORD_BITS];
               pz_ff[cmd.step[1:0] - 2'd1] <= rd_q_ff[COORD_BITS-1:0];
            end
         end
         OP_EDGE: begin
            e_ff[0] <= DIFF_BITS'(px_ff[1]) - DIFF_BITS'(px_ff[0]);
            e_ff[1] <= DIFF_BITS'(py_ff[1]) - DIFF_BITS'(py_ff[0]);
            e_ff[2] <= DIFF_BITS'(pz_ff[1]) - DIFF_BITS'(pz_ff[0]);
            e_ff[3] <= DIFF_BITS'(px_ff[2]) - DIFF_BITS'(px_ff[0]);
            e_ff[4] <= DIFF_BITS'(py_ff[2]) - DIFF_BITS'(py_ff[0]);
            e_ff[5] <= DIFF_BITS'(pz_ff[2]) - DIFF_BITS'(pz_ff[0]);
         end
         OP_MUL: begin
            prod_ff <= mul_a * mul_b;
            if (cmd.step[2:0] != 3'd0) begin
               if (!pair[0]) c_ff[pair[2:1]] <= CROSS_BITS'(prod_ff);
               else c_ff[pair[2:1]] <= c_ff[pair[2:1]] - CROSS_BITS'(prod_ff);
            end
         end
         OP_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i]  <= c_ff[i][CROSS_BITS-1];
               mg_ff[i]   <= c_ff[i][CROSS_BITS-1] ? MAG_BITS'(-c_ff[i])
                                                   : MAG_BITS'(c_ff[i]);
               norm_ff[i] <= '0;
            end
            sum_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               if (mg_or[MAG_BITS-1:31] != '0) mg_ff[i] <= mg_ff[i] >> 1;
               else if (!mg_or[30] && mg_or != '0) mg_ff[i] <= mg_ff[i] << 1;
            end
         end
         OP_SQ: begin
            if (cmd.step[1:0] != 2'd3)
               sq_ff <= 64'(mg_ff[cmd.step[1:0]][30:0] * mg_ff[cmd.step[1:0]][30:0]);
            if (cmd.step[1:0] != 2'd0) sum_ff <= sum_ff + sq_ff;
         end
         OP_SQRT: begin
            sum_ff <= {sum_ff[61:0], 2'b00};
            if (sq_rem_sh >= sq_trial) begin
               rem_ff  <= sq_rem_sh - sq_trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= sq_rem_sh;
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_DIV: begin
            if (cmd.step == '0) begin
               drem_ff <= {2'b00, mg_ff[cmd.comp == 2'd3 ? 2'd0 : cmd.comp][30:0]};
               q_ff    <= '0;
            end else begin
               drem_ff <= div_ge ? div_t - {1'b0, root_ff} : div_t;
               q_ff    <= q_next;
               if (cmd.step == STEP_BITS'(15))
                  norm_ff[cmd.comp == 2'd3 ? 2'd0 : cmd.comp] <=
                     neg_ff[cmd.comp == 2'd3 ? 2'd0 : cmd.comp]
                        ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
            end
         end
         default: begin
         end
      endcase
   end

   assign corner           = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
   assign rsp_vert_x       = px_ff[corner];
   assign rsp_vert_y       = py_ff[corner];
   assign rsp_vert_z       = pz_ff[corner];
   assign rsp_norm_x       = norm_ff[0];
   assign rsp_norm_y       = norm_ff[1];
   assign rsp_norm_z       = norm_ff[2];
   assign rsp_vertex_index = vcnt_ff;
   assign rsp_last_corner  = (corner == 2'd2);
endmodule

// ----- rtl/flat_triangle_normal_expander_unit.sv -----
`timescale 1ns / 1ps
// Expands a triangle of stored nodes into three flat-shaded vertices sharing
// a unit face normal (Q1.14). Node writes and counter restarts are done in
// the idle state without leaving it. A triangle goes through a node fetch
// from the position memory's one read port, 6 multiplies on one shared
// multiplier, a one-bit-per-cycle normalizing shifter (up to 30 shifts),
// the squares of the magnitudes, a 32-step square root and three divisions
// in turn on one divider, then one result per transfer on the output; a
// degenerate triangle goes from the shifter straight to the output. One item
// is in flight at a time.
module flat_triangle_normal_expander_unit
   import ftne_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [COUNT_BITS-1:0]        csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [NODE_BITS-1:0]         req_node_a,
   input  logic [NODE_BITS-1:0]         req_node_b,
   input  logic [NODE_BITS-1:0]         req_node_c,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vert_x,
   output logic signed [COORD_BITS-1:0] rsp_vert_y,
   output logic signed [COORD_BITS-1:0] rsp_vert_z,
   output logic signed [NORM_BITS-1:0]  rsp_norm_x,
   output logic signed [NORM_BITS-1:0]  rsp_norm_y,
   output logic signed [NORM_BITS-1:0]  rsp_norm_z,
   output logic [CNT_BITS-1:0]          rsp_vertex_index,
   output logic                         rsp_last_corner
);
`include "flat_triangle_normal_expander_unit_assert.svh"

   cmd_type cmd;
   sts_type sts;

   ftne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ftne_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_action       (req_action),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .req_node_c       (req_node_c),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_vert_x       (rsp_vert_x),
      .rsp_vert_y       (rsp_vert_y),
      .rsp_vert_z       (rsp_vert_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_corner  (rsp_last_corner)
   );

   `FTNE_ASSERT_NOW(a_one_in_flight, rsp_valid, !req_ready, "input taken during output")
   `FTNE_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last_corner, !rsp_valid,
      "output continues after last corner")
   `FTNE_ASSERT_NOW(a_norm_range, rsp_valid,
      $signed(rsp_norm_x) <= 16384 && $signed(rsp_norm_x) >= -16384,
      "normal out of range")
   `FTNE_ASSERT_NEXT(a_index_step, rsp_valid && rsp_ready && !rsp_last_corner,
      rsp_vertex_index == $past(rsp_vertex_index) + 1'b1, "vertex index skipped")
endmodule
